FILE: rtl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

   // default sizing
   localparam int CordicStepsDefault = 16;
   localparam int FracBitsDefault    = 16;

   // serial multiplier operand and product widths
   localparam int MulW  = 34;
   localparam int ProdW = 2 * MulW;

   // cordic gain in q4.30, turns per radian in binary-angle units (2^32 per turn)
   localparam logic signed [MulW-1:0] CordicGainInv = 34'sd652032874;
   localparam logic [MulW-1:0]        TurnsPerRad   = 34'd683565276;

   // csr register indexes
   typedef enum logic [1:0] {
      CSR_WHEEL_SPEED_SCALE = 2'd0,
      CSR_INV_TRACK_WIDTH   = 2'd1,
      CSR_STEP_TIME         = 2'd2,
      CSR_INV_STEP_TIME     = 2'd3
   } csr_index_type;

   // input beat
   typedef struct packed {
      logic signed [15:0] left_command;
      logic signed [15:0] right_command;
   } req_payload_type;

   // result beat
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] yaw_rate;
      logic signed [31:0] lin_accel;
      logic signed [31:0] ang_accel;
   } rsp_payload_type;

   // arctangent of 2^-i as a binary angle
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] res;
      unique case (idx)
         5'd0:  res = 32'd536870912;
         5'd1:  res = 32'd316933406;
         5'd2:  res = 32'd167458907;
         5'd3:  res = 32'd85004756;
         5'd4:  res = 32'd42667331;
         5'd5:  res = 32'd21354465;
         5'd6:  res = 32'd10680862;
         5'd7:  res = 32'd5340245;
         5'd8:  res = 32'd2670163;
         5'd9:  res = 32'd1335087;
         5'd10: res = 32'd667544;
         5'd11: res = 32'd333772;
         5'd12: res = 32'd166886;
         5'd13: res = 32'd83443;
         5'd14: res = 32'd41721;
         5'd15: res = 32'd20860;
         5'd16: res = 32'd10430;
         5'd17: res = 32'd5215;
         5'd18: res = 32'd2607;
         5'd19: res = 32'd1303;
         5'd20: res = 32'd651;
         5'd21: res = 32'd325;
         5'd22: res = 32'd162;
         5'd23: res = 32'd81;
         5'd24: res = 32'd40;
         5'd25: res = 32'd20;
         5'd26: res = 32'd10;
         5'd27: res = 32'd5;
         5'd28: res = 32'd2;
         5'd29: res = 32'd1;
         default: res = 32'd0;
      endcase
      return res;
   endfunction

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [ProdW-1:0] val);
      logic [ProdW-32:0] upper;
      logic [31:0]       res;
      upper = val[ProdW-1:31];
      if ((&upper) || !(|upper)) begin
         res = val[31:0];
      end else if (val[ProdW-1]) begin
         res = 32'h8000_0000;
      end else begin
         res = 32'h7fff_ffff;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ddo_serial_mult.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_serial_mult
   import ddo_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [MulW-1:0]  op_a,
   input  wire logic signed [MulW-1:0]  op_b,
   output logic                         done,
   output logic signed [ProdW-1:0]      prod
);

   localparam int CntW = $clog2(MulW);
   localparam logic [CntW-1:0] LastCnt = CntW'(MulW - 1);

   logic signed [MulW-1:0] a_ff, a_in;
   logic signed [MulW-1:0] hi_ff, hi_in;
   logic [MulW-1:0]        lo_ff, lo_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic signed [MulW:0]   addend;
   logic signed [MulW:0]   sum;

   // one multiplier bit per cycle, sign bit weighs negative
   always_comb begin
      addend = (cnt_ff == LastCnt) ? -(MulW+1)'(a_ff) : (MulW+1)'(a_ff);
      sum    = (MulW+1)'(hi_ff) + (lo_ff[0] ? addend : '0);
   end

   // next state
   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         hi_in   = '0;
         lo_in   = op_b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MulW:1];
         lo_in  = {sum[0], lo_ff[MulW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastCnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

`default_nettype wire

FILE: rtl/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [31:0]             angle,
   output logic                         done,
   output logic signed [MulW-1:0]       cos_val,
   output logic signed [MulW-1:0]       sin_val
);

   localparam int CntW = $clog2(CORDIC_STEPS + 1);
   localparam logic [CntW-1:0] LastCnt = CntW'(CORDIC_STEPS - 1);

   logic signed [MulW-1:0] x_ff, x_in;
   logic signed [MulW-1:0] y_ff, y_in;
   logic signed [32:0]     z_ff, z_in;
   logic                   flip_ff, flip_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [31:0]            quarter;
   logic                   flip;
   logic [31:0]            folded;
   logic signed [MulW-1:0] dx;
   logic signed [MulW-1:0] dy;
   logic signed [32:0]     step_angle;

   // fold into the right half plane
   always_comb begin
      quarter = angle + 32'h4000_0000;
      flip    = quarter[31];
      folded  = flip ? (angle + 32'h8000_0000) : angle;
   end

   // one rotation per cycle
   always_comb begin
      dx         = y_ff >>> cnt_ff;
      dy         = x_ff >>> cnt_ff;
      step_angle = 33'(atan_entry(5'(cnt_ff)));
   end

   // next state
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CordicGainInv;
         y_in    = '0;
         z_in    = 33'(signed'(folded));
         flip_in = flip;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_angle;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_angle;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastCnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   // undo the half-turn fold
   assign done    = done_ff;
   assign cos_val = flip_ff ? -x_ff : x_ff;
   assign sin_val = flip_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

FILE: rtl/differential_drive_odometry_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          beat
// req       req_valid/req_ready            left and right wheel command
// rsp       rsp_valid/rsp_ready            pose, velocity, rates, accelerations
// csr       psel/penable/pwrite/paddr      four 31-bit registers at 4*index
//
// an item runs 15 steps: 13 bit-serial multiplies (34 bits, one per cycle,
// plus issue and writeback) and two cordic passes of CORDIC_STEPS rotations;
// the result beat is loaded in ST_DONE once the output register is free, and
// the next item is taken in ST_IDLE after that; only one item is in flight.
// all 13 multiplies share the one serial multiplier.
// reset clears pose, history and csr registers to their defaults.
// a finished beat waits in the output register; a new item is taken meanwhile.

module differential_drive_odometry_unit
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault,
   parameter int FRAC_BITS    = FracBitsDefault
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [3:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      SP_VL    = 4'd0,
      SP_VR    = 4'd1,
      SP_W     = 4'd2,
      SP_COS0  = 4'd3,
      SP_C     = 4'd4,
      SP_S     = 4'd5,
      SP_X     = 4'd6,
      SP_Y     = 4'd7,
      SP_DTH   = 4'd8,
      SP_TURN  = 4'd9,
      SP_COS1  = 4'd10,
      SP_VX    = 4'd11,
      SP_VY    = 4'd12,
      SP_LA    = 4'd13,
      SP_AA    = 4'd14
   } step_type;

   typedef enum logic [1:0] {
      SH_WHEEL = 2'd0,
      SH_FRAC  = 2'd1,
      SH_Q30   = 2'd2
   } shift_type;

   state_type       state_ff, state_in;
   step_type        step_ff, step_in;
   shift_type       shift_ff, shift_in;

   logic [30:0]     wheel_scale_ff, inv_track_ff, step_time_ff, inv_step_ff;
   logic [30:0]     wheel_scale_in, inv_track_in, step_time_in, inv_step_in;

   req_payload_type cmd_ff, cmd_in;
   logic signed [31:0] vl_ff, vl_in, vr_ff, vr_in, v_ff, v_in, w_ff, w_in;
   logic signed [31:0] c_ff, c_in, s_ff, s_in, dth_ff, dth_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, la_ff, la_in, aa_ff, aa_in;
   logic signed [MulW-1:0] co_ff, co_in, si_ff, si_in;

   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]        heading_ff, heading_in;
   logic signed [31:0] prev_speed_ff, prev_speed_in, prev_yaw_ff, prev_yaw_in;

   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic                   cordic_step;
   logic                   mul_start, cor_start;
   logic signed [MulW-1:0] mul_a, mul_b;
   logic                   mul_done, cor_done, unit_done;
   logic signed [ProdW-1:0] prod, shifted, pos_sum_x, pos_sum_y;
   logic signed [MulW-1:0] cor_cos, cor_sin;
   logic signed [32:0]     wheel_diff, speed_diff, yaw_diff, wheel_sum;
   logic signed [32:0]     half_sum;
   logic                   csr_write;

   // shared serial multiplier
   ddo_serial_mult u_mult (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   // sine and cosine of the heading
   ddo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (heading_ff),
      .done    (cor_done),
      .cos_val (cor_cos),
      .sin_val (cor_sin)
   );

   // csr port
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      wheel_scale_in = wheel_scale_ff;
      inv_track_in   = inv_track_ff;
      step_time_in   = step_time_ff;
      inv_step_in    = inv_step_ff;
      if (csr_write) begin
         unique case (csr_index_type'(paddr[3:2]))
            CSR_WHEEL_SPEED_SCALE: wheel_scale_in = pwdata[30:0];
            CSR_INV_TRACK_WIDTH:   inv_track_in   = pwdata[30:0];
            CSR_STEP_TIME:         step_time_in   = pwdata[30:0];
            CSR_INV_STEP_TIME:     inv_step_in    = pwdata[30:0];
            default:               wheel_scale_in = wheel_scale_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(paddr[3:2]))
         CSR_WHEEL_SPEED_SCALE: prdata = {1'b0, wheel_scale_ff};
         CSR_INV_TRACK_WIDTH:   prdata = {1'b0, inv_track_ff};
         CSR_STEP_TIME:         prdata = {1'b0, step_time_ff};
         CSR_INV_STEP_TIME:     prdata = {1'b0, inv_step_ff};
         default:               prdata = '0;
      endcase
   end

   // difference terms
   always_comb begin
      wheel_diff = 33'(vr_ff) - 33'(vl_ff);
      wheel_sum  = 33'(vr_ff) + 33'(vl_ff);
      half_sum   = wheel_sum >>> 1;
      speed_diff = 33'(v_ff) - 33'(prev_speed_ff);
      yaw_diff   = 33'(w_ff) - 33'(prev_yaw_ff);
   end

   // operand selection per step
   always_comb begin
      cordic_step = (step_ff == SP_COS0) || (step_ff == SP_COS1);
      mul_a       = '0;
      mul_b       = '0;
      shift_in    = shift_ff;
      unique case (step_ff)
         SP_VL: begin
            mul_a    = MulW'(cmd_ff.left_command);
            mul_b    = MulW'(wheel_scale_ff);
            shift_in = SH_WHEEL;
         end
         SP_VR: begin
            mul_a    = MulW'(cmd_ff.right_command);
            mul_b    = MulW'(wheel_scale_ff);
            shift_in = SH_WHEEL;
         end
         SP_W: begin
            mul_a    = MulW'(wheel_diff);
            mul_b    = MulW'(inv_track_ff);
            shift_in = SH_FRAC;
         end
         SP_C, SP_VX: begin
            mul_a    = MulW'(v_ff);
            mul_b    = co_ff;
            shift_in = SH_Q30;
         end
         SP_S, SP_VY: begin
            mul_a    = MulW'(v_ff);
            mul_b    = si_ff;
            shift_in = SH_Q30;
         end
         SP_X: begin
            mul_a    = MulW'(c_ff);
            mul_b    = MulW'(step_time_ff);
            shift_in = SH_FRAC;
         end
         SP_Y: begin
            mul_a    = MulW'(s_ff);
            mul_b    = MulW'(step_time_ff);
            shift_in = SH_FRAC;
         end
         SP_DTH: begin
            mul_a    = MulW'(w_ff);
            mul_b    = MulW'(step_time_ff);
            shift_in = SH_FRAC;
         end
         SP_TURN: begin
            mul_a    = MulW'(dth_ff);
            mul_b    = signed'(TurnsPerRad);
            shift_in = SH_FRAC;
         end
         SP_LA: begin
            mul_a    = MulW'(speed_diff);
            mul_b    = MulW'(inv_step_ff);
            shift_in = SH_FRAC;
         end
         SP_AA: begin
            mul_a    = MulW'(yaw_diff);
            mul_b    = MulW'(inv_step_ff);
            shift_in = SH_FRAC;
         end
         default: begin
            mul_a = '0;
         end
      endcase
      if (state_ff != ST_ISSUE) begin
         shift_in = shift_ff;
      end
   end

   assign mul_start = (state_ff == ST_ISSUE) && !cordic_step;
   assign cor_start = (state_ff == ST_ISSUE) && cordic_step;
   assign unit_done = cordic_step ? cor_done : mul_done;

   // product scaling
   always_comb begin
      unique case (shift_ff)
         SH_WHEEL: shifted = prod >>> 15;
         SH_FRAC:  shifted = prod >>> FRAC_BITS;
         SH_Q30:   shifted = prod >>> 30;
         default:  shifted = prod;
      endcase
      pos_sum_x = shifted + ProdW'(x_ff);
      pos_sum_y = shifted + ProdW'(y_ff);
   end

   // sequencer and writeback
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      vl_in = vl_ff;  vr_in = vr_ff;  v_in = v_ff;   w_in = w_ff;
      c_in  = c_ff;   s_in  = s_ff;   dth_in = dth_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  la_in = la_ff; aa_in = aa_ff;
      co_in = co_ff;  si_in = si_ff;
      x_in  = x_ff;   y_in  = y_ff;   heading_in = heading_ff;
      prev_speed_in = prev_speed_ff;
      prev_yaw_in   = prev_yaw_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload;
               step_in  = SP_VL;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               state_in = ST_ISSUE;
               step_in  = step_type'(step_ff + 4'd1);
               unique case (step_ff)
                  SP_VL:   vl_in = sat32(shifted);
                  SP_VR:   vr_in = sat32(shifted);
                  SP_W: begin
                     w_in = sat32(shifted);
                     v_in = half_sum[31:0];
                  end
                  SP_COS0, SP_COS1: begin
                     co_in = cor_cos;
                     si_in = cor_sin;
                  end
                  SP_C:    c_in = sat32(shifted);
                  SP_S:    s_in = sat32(shifted);
                  SP_X:    x_in = sat32(pos_sum_x);
                  SP_Y:    y_in = sat32(pos_sum_y);
                  SP_DTH:  dth_in = sat32(shifted);
                  SP_TURN: heading_in = heading_ff + shifted[31:0];
                  SP_VX:   vx_in = sat32(shifted);
                  SP_VY:   vy_in = sat32(shifted);
                  SP_LA:   la_in = sat32(shifted);
                  SP_AA: begin
                     aa_in       = sat32(shifted);
                     prev_yaw_in = w_ff;
                     if (v_ff == 32'sh8000_0000) begin
                        prev_speed_in = 32'sh7fff_ffff;
                     end else if (v_ff[31]) begin
                        prev_speed_in = -v_ff;
                     end else begin
                        prev_speed_in = v_ff;
                     end
                     state_in = ST_DONE;
                     step_in  = SP_VL;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.pos_x     = x_ff;
               rsp_in.pos_y     = y_ff;
               rsp_in.heading   = heading_ff;
               rsp_in.vel_x     = vx_ff;
               rsp_in.vel_y     = vy_ff;
               rsp_in.yaw_rate  = w_ff;
               rsp_in.lin_accel = la_ff;
               rsp_in.ang_accel = aa_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= SP_VL;
         shift_ff       <= SH_WHEEL;
         rsp_valid_ff   <= 1'b0;
         wheel_scale_ff <= 31'd65536;
         inv_track_ff   <= 31'd131072;
         step_time_ff   <= 31'd655;
         inv_step_ff    <= 31'd6553600;
         x_ff           <= '0;
         y_ff           <= '0;
         heading_ff     <= '0;
         prev_speed_ff  <= '0;
         prev_yaw_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         shift_ff       <= shift_in;
         rsp_valid_ff   <= rsp_valid_in;
         wheel_scale_ff <= wheel_scale_in;
         inv_track_ff   <= inv_track_in;
         step_time_ff   <= step_time_in;
         inv_step_ff    <= inv_step_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         heading_ff     <= heading_in;
         prev_speed_ff  <= prev_speed_in;
         prev_yaw_ff    <= prev_yaw_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      vl_ff  <= vl_in;
      vr_ff  <= vr_in;
      v_ff   <= v_in;
      w_ff   <= w_in;
      c_ff   <= c_in;
      s_ff   <= s_in;
      dth_ff <= dth_in;
      vx_ff  <= vx_in;
      vy_ff  <= vy_in;
      la_ff  <= la_in;
      aa_ff  <= aa_in;
      co_ff  <= co_in;
      si_ff  <= si_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ddo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_checker
   import ddo_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire req_payload_type req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_payload,
   input wire logic            psel,
   input wire logic            penable,
   input wire logic            pwrite,
   input wire logic [3:0]      paddr,
   input wire logic [31:0]     pwdata,
   input wire logic [31:0]     prdata,
   input wire logic            pready
);

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   // the block is busy right after it takes an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted item");

   // no result can rise in the cycle after an item is taken
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // csr port never stalls
   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel |-> pready)
      else $error("csr port stalled");

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (.*);

`default_nettype wire
